// ===== rtl/pe_pkg.sv =====
// Shared types and constants for the Horner polynomial evaluator.
package pe_pkg;

  // Q16.16 data format
  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int PROD_W = 2 * DATA_W;

  // Coefficient register file
  localparam int COEF_REGS = 8;
  localparam int COEF_IDX_W = $clog2(COEF_REGS);
  localparam int CFG_INDEX_W = 8;

  // Default number of polynomial terms (degree + 1)
  localparam int NUM_TERMS_DEF = 8;

  typedef logic signed [DATA_W-1:0] q16_t;
  typedef q16_t [COEF_REGS-1:0] coef_bank_t;

  localparam q16_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam q16_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // One item moving down the Horner chain
  typedef struct packed {
    logic valid;
    logic sat;
    q16_t acc;
    q16_t x;
  } lane_t;

endpackage

// ===== rtl/pe_coef_regs.sv =====
// Coefficient register file written through the configuration channel.
module pe_coef_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  pe_pkg::q16_t                   cfg_data,
  output pe_pkg::coef_bank_t             coef
);
  import pe_pkg::*;

  logic index_ok;

  // Drop writes beyond the register list
  assign index_ok = cfg_index < CFG_INDEX_W'(COEF_REGS);

  // Store one coefficient per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (cfg_we && index_ok) begin
      coef[cfg_index[COEF_IDX_W-1:0]] <= cfg_data;
    end
  end

endmodule

// ===== rtl/pe_horner_step.sv =====
// One Horner step: registered multiply, then add, floor shift and saturate.
module pe_horner_step (
  input  logic          clk,
  input  logic          rst,
  input  pe_pkg::lane_t lane_in,
  input  pe_pkg::q16_t  coef,
  output pe_pkg::lane_t lane_out
);
  import pe_pkg::*;

  localparam int SHIFT_W = PROD_W - FRAC_W;

  logic                      mul_valid;
  logic                      mul_sat;
  q16_t                      mul_x;
  logic signed [PROD_W-1:0]  mul_prod;

  logic signed [PROD_W-1:0]  prod_next;
  logic signed [PROD_W-1:0]  coef_ext;
  logic signed [PROD_W-1:0]  full;
  logic signed [SHIFT_W-1:0] shifted;
  logic                      ovf_hi;
  logic                      ovf_lo;
  q16_t                      acc_next;

  // Full product of accumulator and sample
  assign prod_next = PROD_W'(lane_in.acc) * PROD_W'(lane_in.x);

  // Hold the product for the add stage
  always_ff @(posedge clk) begin
    mul_prod <= prod_next;
    mul_x    <= lane_in.x;
    mul_sat  <= lane_in.sat;
    if (rst) begin
      mul_valid <= 1'b0;
    end else begin
      mul_valid <= lane_in.valid;
    end
  end

  // Add the coefficient aligned to Q32.32, drop the low fraction bits
  assign coef_ext = {{(PROD_W-DATA_W-FRAC_W){coef[DATA_W-1]}}, coef, {FRAC_W{1'b0}}};
  assign full     = mul_prod + coef_ext;
  assign shifted  = full[PROD_W-1:FRAC_W];

  // Clamp when the upper bits are not a sign extension
  assign ovf_hi   = !shifted[SHIFT_W-1] && (|shifted[SHIFT_W-2:DATA_W-1]);
  assign ovf_lo   = shifted[SHIFT_W-1] && !(&shifted[SHIFT_W-2:DATA_W-1]);
  assign acc_next = ovf_hi ? Q_MAX : (ovf_lo ? Q_MIN : shifted[DATA_W-1:0]);

  // Register the step result
  always_ff @(posedge clk) begin
    lane_out.acc <= acc_next;
    lane_out.x   <= mul_x;
    lane_out.sat <= mul_sat | ovf_hi | ovf_lo;
    if (rst) begin
      lane_out.valid <= 1'b0;
    end else begin
      lane_out.valid <= mul_valid;
    end
  end

endmodule

// ===== rtl/polynomial_evaluator.sv =====
// Top level of the pipelined Horner polynomial evaluator.
//
//   Channel   Handshake                 Payload
//   --------  ------------------------  ---------------------------------
//   input     start (busy held low)     x_value
//   result    done, one-cycle strobe    y_value, saturated
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One sample is taken per cycle. Each Horner step is a multiply stage followed
// by an add / shift / saturate stage, and a result passes through both registered
// stages of every step. Synchronous reset clears the valid bits and all
// coefficients. Nothing stalls: the result strobe cannot be held off, so
// busy stays low and cfg_ready stays high.
module polynomial_evaluator #(
  parameter int NUM_TERMS = pe_pkg::NUM_TERMS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  pe_pkg::q16_t                   x_value,
  output logic                           done,
  output pe_pkg::q16_t                   y_value,
  output logic                           saturated,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  pe_pkg::q16_t                   cfg_data
);
  import pe_pkg::*;

  localparam int STEPS = NUM_TERMS - 1;

  coef_bank_t coef;
  lane_t      chain [STEPS+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Coefficient storage
  pe_coef_regs u_coef_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  // Seed the chain with the highest used coefficient
  always_comb begin
    chain[0].valid = start & !busy;
    chain[0].sat   = 1'b0;
    chain[0].acc   = coef[NUM_TERMS-1];
    chain[0].x     = x_value;
  end

  // One step per lower coefficient, highest first
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    pe_horner_step u_step (
      .clk      (clk),
      .rst      (rst),
      .lane_in  (chain[i]),
      .coef     (coef[NUM_TERMS-2-i]),
      .lane_out (chain[i+1])
    );
  end

  // Drive the result from the last step
  assign done      = chain[STEPS].valid;
  assign y_value   = chain[STEPS].acc;
  assign saturated = chain[STEPS].sat;

endmodule

// ===== rtl/pe_checker.sv =====
// Port-level checker for the polynomial evaluator, bound to the top level.
module pe_checker #(
  parameter int NUM_TERMS = pe_pkg::NUM_TERMS_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input pe_pkg::q16_t                   x_value,
  input logic                           done,
  input pe_pkg::q16_t                   y_value,
  input logic                           saturated,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [pe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input pe_pkg::q16_t                   cfg_data
);
  import pe_pkg::*;

  localparam int LATENCY = 2 * (NUM_TERMS - 1);
  localparam int CNT_W   = $clog2(LATENCY + 1);

  logic [CNT_W-1:0] warm_cnt;
  logic             warm;
  q16_t             coef0_shadow;

  assign warm = warm_cnt == CNT_W'(LATENCY);

  // Count cycles since reset up to the pipeline latency
  always_ff @(posedge clk) begin
    if (rst) begin
      warm_cnt <= '0;
    end else if (!warm) begin
      warm_cnt <= warm_cnt + CNT_W'(1);
    end
  end

  // Track the constant term
  always_ff @(posedge clk) begin
    if (rst) begin
      coef0_shadow <= '0;
    end else if (cfg_valid && cfg_ready && cfg_index == '0) begin
      coef0_shadow <= cfg_data;
    end
  end

  // Every accepted sample gives one result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    warm |-> done == $past(start && !busy, LATENCY))
    else $error("result strobe does not match accepted transaction");

  // No result before the pipeline has refilled after reset
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    !warm |-> !done)
    else $error("result strobe before pipeline refilled");

  // A zero sample yields the constant term without saturation
  a_zero_x: assert property (@(posedge clk) disable iff (rst)
    (warm && done && $past(x_value == '0, LATENCY))
      |-> (y_value == $past(coef0_shadow) && !saturated))
    else $error("zero sample did not return constant term");

endmodule

bind polynomial_evaluator pe_checker #(.NUM_TERMS(NUM_TERMS)) u_pe_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .x_value   (x_value),
  .done      (done),
  .y_value   (y_value),
  .saturated (saturated),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);

// ===== dv/pe_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the polynomial evaluator: Horner-rule prediction and result compare.
module pe_scoreboard #(
  parameter int NUM_TERMS = pe_pkg::NUM_TERMS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  pe_pkg::q16_t                   x_value,
  input  logic                           done,
  input  pe_pkg::q16_t                   y_value,
  input  logic                           saturated,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [pe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  pe_pkg::q16_t                   cfg_data,
  output int                             pending,
  output int                             fail_count
);
  import pe_pkg::*;

  typedef struct {
    q16_t y;
    logic sat;
  } poly_value_t;

  q16_t        coef_shadow [COEF_REGS];
  poly_value_t poly_value_q[$];
  int          mismatches = 0;

  // Evaluate the polynomial at x by Horner's rule in Q16.16, clamping every step
  function automatic poly_value_t horner_value(q16_t x);
    poly_value_t r;
    longint      acc;
    longint      sum;
    longint      step;
    r.sat = 1'b0;
    acc   = longint'(coef_shadow[NUM_TERMS-1]);
    for (int k = NUM_TERMS - 2; k >= 0; k--) begin
      sum  = acc * longint'(x) + (longint'(coef_shadow[k]) <<< FRAC_W);
      // arithmetic shift floors toward minus infinity
      step = sum >>> FRAC_W;
      if (step > longint'(Q_MAX)) begin
        step  = longint'(Q_MAX);
        r.sat = 1'b1;
      end else if (step < longint'(Q_MIN)) begin
        step  = longint'(Q_MIN);
        r.sat = 1'b1;
      end
      acc = step;
    end
    r.y = q16_t'(acc);
    return r;
  endfunction

  // Watch all three channels at each rising edge
  always @(posedge clk) begin : watch
    poly_value_t want;
    if (rst) begin
      foreach (coef_shadow[i]) coef_shadow[i] = '0;
      poly_value_q.delete();
    end else begin
      // predict with the coefficients held before this edge
      if (start && !busy) begin
        poly_value_q.push_back(horner_value(x_value));
      end
      // drop writes to indexes past the coefficient bank
      if (cfg_valid && cfg_ready && cfg_index < COEF_REGS) begin
        coef_shadow[cfg_index[COEF_IDX_W-1:0]] = cfg_data;
      end
      // compare each result transaction with the oldest prediction
      if (done) begin
        if (poly_value_q.size() == 0) begin
          $error("unexpected result: y_value %h saturated %b", y_value, saturated);
          mismatches++;
        end else begin
          want = poly_value_q.pop_front();
          if (y_value !== want.y) begin
            $error("y_value mismatch: expected %h, actual %h", want.y, y_value);
            mismatches++;
          end
          if (saturated !== want.sat) begin
            $error("saturated mismatch: expected %b, actual %b", want.sat, saturated);
            mismatches++;
          end
        end
      end
    end
    pending    <= poly_value_q.size();
    fail_count <= mismatches;
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for the polynomial evaluator, with the scoreboard beside it.
module tb_top;
  import pe_pkg::*;

  localparam int   TERMS       = NUM_TERMS_DEF;
  localparam int   PIPE_LAT    = 2 * (TERMS - 1);
  localparam int   SEGMENTS    = 12;
  localparam int   SEG_ITEMS   = 108;
  localparam q16_t Q_ONE       = 32'sh0001_0000;
  localparam q16_t Q_HALF      = 32'sh0000_8000;
  localparam q16_t Q_LSB       = 32'sh0000_0001;
  localparam q16_t Q_NEG_LSB   = -32'sh0000_0001;
  localparam logic [CFG_INDEX_W-1:0] IDX_PAST_BANK = CFG_INDEX_W'(COEF_REGS);
  localparam logic [CFG_INDEX_W-1:0] IDX_TOP       = '1;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  q16_t                   x_value = '0;
  logic                   done;
  q16_t                   y_value;
  logic                   saturated;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  q16_t                   cfg_data = '0;
  int                     pending;
  int                     fail_count;
  int                     idle_pct = 0;

  polynomial_evaluator #(.NUM_TERMS(TERMS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .x_value(x_value),
    .done(done), .y_value(y_value), .saturated(saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  pe_scoreboard #(.NUM_TERMS(TERMS)) checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .x_value(x_value),
    .done(done), .y_value(y_value), .saturated(saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pending(pending), .fail_count(fail_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #4_000_000;
    $display("polynomial_evaluator verification failed");
    $finish;
  end

  // Random Q16.16 value spread over +/- 2^(span-1) LSBs
  function automatic q16_t rand_q(int span);
    q16_t v;
    v = $urandom;
    return v >>> (DATA_W - span);
  endfunction

  // Present one sample after a random gap; return once it is taken
  task automatic send_x(q16_t x);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    x_value <= x;
    do @(posedge clk); while (busy);
  endtask

  // Hold the sample channel until every prediction is matched, then let the pipe empty
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  // One register write transaction; valid stays high for a following write
  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, q16_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_bank(input q16_t bank [COEF_REGS]);
    for (int i = 0; i < COEF_REGS; i++) cfg_write(CFG_INDEX_W'(i), bank[i]);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Pick a coefficient set of random style and degree
  task automatic random_bank();
    q16_t bank [COEF_REGS];
    int   style;
    int   degree;
    style  = $urandom_range(3);
    degree = $urandom_range(COEF_REGS - 1);
    foreach (bank[i]) begin
      case (style)
        0: bank[i] = rand_q(18);
        1: bank[i] = rand_q(20);
        2: bank[i] = rand_q(32);
        default: bank[i] = (i <= degree) ? rand_q(19) : '0;
      endcase
      if ($urandom_range(15) == 0) bank[i] = $urandom_range(1) ? Q_MAX : Q_MIN;
    end
    load_bank(bank);
    // ignored write past the end of the bank
    if ($urandom_range(2) == 0) begin
      cfg_write(CFG_INDEX_W'($urandom_range(COEF_REGS, 255)), $urandom);
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin
    q16_t bank [COEF_REGS];
    int   pick;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all coefficients zero after reset
    send_x('0);
    send_x(Q_MAX);
    send_x(Q_MIN);
    drain();

    // p(x) = x/2: extremes and floor of odd LSBs
    foreach (bank[i]) bank[i] = '0;
    bank[1] = Q_HALF;
    load_bank(bank);
    send_x(Q_MAX);
    send_x(Q_MIN);
    send_x(Q_NEG_LSB);
    send_x(Q_LSB);
    send_x(3 * Q_LSB);
    drain();

    // every coefficient at the positive bound: steps overflow both ways
    foreach (bank[i]) bank[i] = Q_MAX;
    load_bank(bank);
    send_x(Q_MAX);
    send_x(Q_MIN);
    send_x('0);
    drain();

    // every coefficient at the negative bound
    foreach (bank[i]) bank[i] = Q_MIN;
    load_bank(bank);
    send_x(Q_MAX);
    send_x(Q_HALF);
    send_x('0);
    drain();

    // small quadratic, with writes past the bank that must be dropped
    foreach (bank[i]) bank[i] = '0;
    bank[0] = -(Q_ONE + Q_HALF);
    bank[2] = 2 * Q_ONE;
    load_bank(bank);
    cfg_write(IDX_PAST_BANK, Q_MAX);
    cfg_write(IDX_TOP, Q_MIN);
    cfg_valid <= 1'b0;
    @(posedge clk);
    send_x(-Q_HALF);
    send_x(Q_ONE);
    drain();

    // random segments: sender idles 21%, then 54%, then never
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      idle_pct = (seg < SEGMENTS / 3) ? 21 : (seg < 2 * SEGMENTS / 3) ? 54 : 0;
      random_bank();
      for (int n = 0; n < SEG_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 55) send_x(rand_q(18));
        else if (pick < 85) send_x(rand_q(22));
        else send_x(rand_q(32));
        if ($urandom_range(99) == 0) drain();
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("polynomial_evaluator verification clean");
    end else begin
      $display("polynomial_evaluator verification failed");
    end
    $finish;
  end

endmodule

// ===== polynomial_evaluator.f =====
rtl/pe_pkg.sv
rtl/pe_coef_regs.sv
rtl/pe_horner_step.sv
rtl/polynomial_evaluator.sv
rtl/pe_checker.sv
dv/pe_checker.sv
dv/tb_top.sv
